/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the Q-learning engine RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define QLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qle assertion failed");

// Condition must never be seen outside reset.
`define QLE_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("qle forbidden condition seen");

`endif

/* hw/rtl/qle_pkg.sv */
// Types, codes and constants of the tabular Q-learning engine.
// No dependencies; used by qle_store and the top level.
package qle_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;
  localparam logic [1:0] OP_GREEDY = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOCAND  = 2'd1;
  localparam logic [1:0] ST_NONPOS  = 2'd2;

  // Reward codes
  localparam logic [1:0] CODE_NONE    = 2'd0;
  localparam logic [1:0] CODE_ZERO    = 2'd1;
  localparam logic [1:0] CODE_HUNDRED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GAMMA = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_NODES = 2'd2;

  localparam int QW = 24;
  localparam logic [15:0] GAMMA_RESET = 16'd52429;
  localparam logic [8:0]  NODES_RESET = 9'd16;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  from_node;
    logic [7:0]  to_node;
    logic [14:0] random_value;
  } req_t;

  typedef struct packed {
    logic [7:0]         chosen_node;
    logic signed [31:0] score;
    logic [1:0]         status;
  } rsp_t;

  // Write request into the table store
  typedef struct packed {
    logic                 r_we;
    logic [1:0]           code;
    logic                 q_we;
    logic signed [QW-1:0] qv;
  } mem_wr_t;

  // Reward of a code in Q8.8; unknown codes read as none
  function automatic logic signed [15:0] reward_raw(input logic [1:0] code);
    logic signed [15:0] r;
    case (code)
      CODE_ZERO:    r = 16'sd0;
      CODE_HUNDRED: r = 16'sd25600;
      default:      r = -16'sd256;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/qle_store.sv */
// Reward and Q value tables: two synchronous RAMs, goal marks, clear sweep.
// Depends on qle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qle_store #(
  parameter int NW = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [NW-1:0]              rd_row,
  input  logic [NW-1:0]              rd_col,
  input  logic [NW-1:0]              wr_row,
  input  logic [NW-1:0]              wr_col,
  input  qle_pkg::mem_wr_t           wr,
  input  logic                       goal_set,
  input  logic [NW-1:0]              goal_node,
  output logic [1:0]                 rd_code,
  output logic signed [qle_pkg::QW-1:0] rd_q,
  output logic                       clearing
);

  localparam int AW    = 2 * NW;
  localparam int DEPTH = 1 << AW;
  localparam int MARKW = 1 << NW;

  logic [1:0]             code_mem [DEPTH];
  logic [qle_pkg::QW-1:0] q_mem    [DEPTH];
  logic [AW-1:0]          clr_addr;
  logic [MARKW-1:0]       mark;
  logic [1:0]             code_rd;
  logic                   ovr;
  logic [AW-1:0]          w_addr;
  logic                   w_r, w_q;
  logic [1:0]             w_code;
  logic [qle_pkg::QW-1:0] w_qv;

  // Write port: clear sweep owns it after reset
  always_comb begin
    w_addr = clearing ? clr_addr : {wr_row, wr_col};
    w_r    = clearing | wr.r_we;
    w_q    = clearing | wr.q_we;
    w_code = clearing ? qle_pkg::CODE_NONE : wr.code;
    w_qv   = clearing ? '0 : wr.qv;
  end

  always_ff @(posedge clk) begin
    if (w_r) begin
      code_mem[w_addr] <= w_code;
    end
    if (w_q) begin
      q_mem[w_addr] <= w_qv;
    end
  end

  // Registered read; marked goal diagonal reads as hundred
  always_ff @(posedge clk) begin
    code_rd <= code_mem[{rd_row, rd_col}];
    rd_q    <= q_mem[{rd_row, rd_col}];
    ovr     <= (rd_row == rd_col) && mark[rd_row];
  end

  assign rd_code = ovr ? qle_pkg::CODE_HUNDRED : code_rd;

  // Clear sweep over every entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Goal marks: set by a goal write, dropped when the diagonal is rewritten
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= MARKW'(1);
    end else begin
      if (wr.r_we && (wr_row == wr_col)) begin
        mark[wr_row] <= 1'b0;
      end
      if (goal_set) begin
        mark[goal_node] <= 1'b1;
      end
    end
  end

  `QLE_NEVER(no_write_in_clear, clk, rst, clearing && (wr.r_we || wr.q_we))

endmodule

/* hw/rtl/qle_div.sv */
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module qle_div #(
  parameter int DW = 47,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CNTW = $clog2(DW + 1);

  logic            active;
  logic [CNTW-1:0] cnt;
  logic [VW-1:0]   dvs;
  logic [VW:0]     rem_sh;
  logic [VW:0]     diff;
  logic            ge;

  always_comb begin
    rem_sh = {remainder, quotient[DW-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = !diff[VW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
        cnt       <= CNTW'(DW);
        active    <= 1'b1;
      end else if (active) begin
        quotient  <= {quotient[DW-2:0], ge};
        remainder <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
        cnt       <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  `QLE_ASSERT(rem_below_divisor, clk, rst, done && (dvs != '0) |-> remainder < dvs)

endmodule

/* hw/rtl/tabular_q_learning_engine.sv */
// Top level of the tabular Q-learning engine: sequencer, config, result.
// Depends on qle_pkg, qle_store, qle_div and assert_macros.svh.
//
// Usage:
//  - A request is taken at a clock edge with start high and busy low.
//    Exactly one result follows, shown on result for one cycle with done
//    high. The receiver cannot stall; results must be taken as they come.
//  - Config writes (cfg_write, cfg_index, cfg_data) land at the next edge
//    and must be made only while the block is idle; it does not enforce this.
//  - Reset starts a clear sweep of every entry of both tables; busy stays
//    high during it.
//  - The divider runs SW+7 division steps (39 at 16 nodes).
//    add_connection writes two table entries, none when a node is invalid.
//    select_action and greedy_step scan the row of from_node and divide.
//    update walks the whole Q table through its single read port, one
//    entry per cycle.
//  - One request at a time; busy stays high until the result is out.
`include "assert_macros.svh"

module tabular_q_learning_engine #(
  parameter int MAX_NODES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  qle_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output qle_pkg::rsp_t result,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int NW  = (MAX_NODES <= 2) ? 1 : $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int SW  = qle_pkg::QW + 2 * NW;
  localparam int DVW = SW + 7;
  localparam int QW  = qle_pkg::QW;
  localparam logic [DVW-1:0] POS_LIM = DVW'(32'h7FFF_FFFF);
  localparam logic [DVW-1:0] NEG_LIM = DVW'(32'h8000_0000);

  typedef enum logic [15:0] {
    S_IDLE = 16'b0000_0000_0000_0001,
    S_ADD1 = 16'b0000_0000_0000_0010,
    S_ADD2 = 16'b0000_0000_0000_0100,
    S_RMAX = 16'b0000_0000_0000_1000,
    S_CNT  = 16'b0000_0000_0001_0000,
    S_DIVW = 16'b0000_0000_0010_0000,
    S_FIND = 16'b0000_0000_0100_0000,
    S_URD  = 16'b0000_0000_1000_0000,
    S_URC  = 16'b0000_0001_0000_0000,
    S_UMUL = 16'b0000_0010_0000_0000,
    S_URND = 16'b0000_0100_0000_0000,
    S_UWR  = 16'b0000_1000_0000_0000,
    S_SUM  = 16'b0001_0000_0000_0000,
    S_SCL  = 16'b0010_0000_0000_0000,
    S_SABS = 16'b0100_0000_0000_0000,
    S_UFIN = 16'b1000_0000_0000_0000
  } state_t;

  state_t state;
  qle_pkg::req_t cur;

  // Config registers
  logic [15:0] gamma;
  logic [7:0]  end_node;
  logic [8:0]  node_count;

  logic [CW-1:0] n_use, n_cur, n_m1;

  // Row/table scan
  logic          issuing, whole, fresh, pvld, pfirst;
  logic [CW-1:0] col;
  logic [NW-1:0] srow, pcol;
  logic          is_scan, scan_done, hit;

  // Datapath registers
  logic signed [QW-1:0] m, tmax;
  logic [CW-1:0]        cnt, k, pick;
  logic                 found;
  logic [7:0]           chosen;
  logic [1:0]           rcode;
  logic signed [40:0]   prod;
  logic signed [40:0]   prnd;
  logic signed [24:0]   rndv;
  logic signed [25:0]   qsum;
  logic signed [QW-1:0] qsat;
  logic signed [SW-1:0] sum, q_ext;
  logic signed [DVW-1:0] p100, sum_x;
  logic                 neg;
  logic [31:0]          score_sat;

  // Divider
  logic           div_start, div_done;
  logic [DVW-1:0] div_dvd, div_quo;
  logic [QW-1:0]  div_dvs, div_rem;

  // Store ports
  logic [NW-1:0]        rd_row, rd_col, wr_row, wr_col;
  qle_pkg::mem_wr_t     wr;
  logic                 goal_set;
  logic [1:0]           rd_code;
  logic signed [QW-1:0] rd_q;
  logic                 clearing;

  logic accept, from_ok, to_ok;

  // Nodes in use: node_count clamped to 2..MAX_NODES
  always_comb begin
    if (node_count < 9'd2) begin
      n_use = CW'(2);
    end else if (node_count > 9'(MAX_NODES)) begin
      n_use = CW'(MAX_NODES);
    end else begin
      n_use = CW'(node_count);
    end
  end

  assign n_m1    = n_cur - 1'b1;
  assign busy    = clearing || (state != S_IDLE);
  assign accept  = start && !busy;
  assign from_ok = {1'b0, request.from_node} < 9'(n_use);
  assign to_ok   = {1'b0, request.to_node} < 9'(n_use);
  assign goal_set = cfg_write && (cfg_index == qle_pkg::CFG_END) &&
                    (9'(cfg_data[7:0]) < 9'(MAX_NODES));

  assign is_scan   = (state == S_RMAX) || (state == S_CNT) ||
                     (state == S_FIND) || (state == S_SUM);
  assign scan_done = !issuing && !pvld;

  // Candidate test: connected edge for select, row maximum for greedy
  assign hit = (cur.operation == qle_pkg::OP_SELECT) ?
               ((rd_code == qle_pkg::CODE_ZERO) || (rd_code == qle_pkg::CODE_HUNDRED)) :
               (rd_q == m);

  // Update arithmetic: round the discounted max, add reward, saturate
  assign prnd = prod + 41'sd32768;
  assign qsum = {rndv[24], rndv} + 26'(qle_pkg::reward_raw(rcode));
  always_comb begin
    if (qsum > 26'sd8388607) begin
      qsat = 24'sh7FFFFF;
    end else if (qsum < -26'sd8388608) begin
      qsat = 24'sh800000;
    end else begin
      qsat = qsum[QW-1:0];
    end
  end

  assign q_ext = {{(SW-QW){rd_q[QW-1]}}, rd_q};
  assign sum_x = {{7{sum[SW-1]}}, sum};

  // Score saturation of the signed quotient
  always_comb begin
    if (!neg) begin
      score_sat = (div_quo > POS_LIM) ? 32'h7FFF_FFFF : div_quo[31:0];
    end else begin
      score_sat = (div_quo > NEG_LIM) ? 32'h8000_0000 : (32'd0 - div_quo[31:0]);
    end
  end

  // Read address
  always_comb begin
    if (state == S_URD) begin
      rd_row = cur.from_node[NW-1:0];
      rd_col = cur.to_node[NW-1:0];
    end else begin
      rd_row = srow;
      rd_col = col[NW-1:0];
    end
  end

  // Write requests to the store
  always_comb begin
    wr     = '0;
    wr_row = cur.from_node[NW-1:0];
    wr_col = cur.to_node[NW-1:0];
    case (state)
      S_ADD1: begin
        wr.r_we = 1'b1;
        wr.code = qle_pkg::CODE_ZERO;
        if (cur.to_node == end_node) begin
          wr_row = cur.to_node[NW-1:0];
          wr_col = cur.from_node[NW-1:0];
        end
      end
      S_ADD2: begin
        wr.r_we = 1'b1;
        if (cur.to_node == end_node) begin
          wr.code = qle_pkg::CODE_HUNDRED;
        end else begin
          wr.code = qle_pkg::CODE_ZERO;
          wr_row  = cur.to_node[NW-1:0];
          wr_col  = cur.from_node[NW-1:0];
        end
      end
      S_UWR: begin
        wr.q_we = 1'b1;
        wr.qv   = qsat;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma      <= qle_pkg::GAMMA_RESET;
      end_node   <= 8'd0;
      node_count <= qle_pkg::NODES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        qle_pkg::CFG_GAMMA: gamma      <= cfg_data;
        qle_pkg::CFG_END:   end_node   <= cfg_data[7:0];
        qle_pkg::CFG_NODES: node_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
      issuing   <= 1'b0;
      pvld      <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;

      // Scan issue: one entry read per cycle, its data valid in the next cycle
      if (is_scan && issuing) begin
        pvld   <= 1'b1;
        pcol   <= col[NW-1:0];
        pfirst <= fresh;
        fresh  <= 1'b0;
        if (col == n_m1) begin
          col <= '0;
          if (whole && ({1'b0, srow} != CW'(n_m1))) begin
            srow <= srow + 1'b1;
          end else begin
            issuing <= 1'b0;
          end
        end else begin
          col <= col + 1'b1;
        end
      end else begin
        pvld <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cur   <= request;
            n_cur <= n_use;
            case (request.operation)
              qle_pkg::OP_ADD: begin
                if (from_ok && to_ok) begin
                  state <= S_ADD1;
                end else begin
                  result <= '{chosen_node: 8'd0, score: 32'sd0, status: qle_pkg::ST_OK};
                  done   <= 1'b1;
                end
              end
              qle_pkg::OP_UPDATE: begin
                if (from_ok && to_ok) begin
                  state <= S_URD;
                end else begin
                  col <= '0; srow <= '0; whole <= 1'b1; issuing <= 1'b1; fresh <= 1'b1;
                  state <= S_SUM;
                end
              end
              qle_pkg::OP_SELECT: begin
                if (from_ok) begin
                  col <= '0; srow <= request.from_node[NW-1:0]; whole <= 1'b0;
                  issuing <= 1'b1; fresh <= 1'b1; cnt <= '0;
                  state <= S_CNT;
                end else begin
                  result <= '{chosen_node: 8'd0, score: 32'sd0, status: qle_pkg::ST_NOCAND};
                  done   <= 1'b1;
                end
              end
              default: begin
                if (from_ok) begin
                  col <= '0; srow <= request.from_node[NW-1:0]; whole <= 1'b0;
                  issuing <= 1'b1; fresh <= 1'b1;
                  state <= S_RMAX;
                end else begin
                  result <= '{chosen_node: 8'd0, score: 32'sd0, status: qle_pkg::ST_NOCAND};
                  done   <= 1'b1;
                end
              end
            endcase
          end
        end
        S_ADD1: state <= S_ADD2;
        S_ADD2: begin
          result <= '{chosen_node: 8'd0, score: 32'sd0, status: qle_pkg::ST_OK};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        // Row maximum
        S_RMAX: begin
          if (pvld) begin
            m <= (pfirst || (rd_q > m)) ? rd_q : m;
          end
          if (scan_done) begin
            if (cur.operation == qle_pkg::OP_GREEDY) begin
              col <= '0; srow <= cur.from_node[NW-1:0]; whole <= 1'b0;
              issuing <= 1'b1; fresh <= 1'b1; cnt <= '0;
              state <= S_CNT;
            end else begin
              state <= S_UMUL;
            end
          end
        end
        // Candidate count, then pick = random mod count
        S_CNT: begin
          if (pvld && hit) begin
            cnt <= cnt + 1'b1;
          end
          if (scan_done) begin
            if (cnt == '0) begin
              result <= '{chosen_node: 8'd0, score: 32'sd0, status: qle_pkg::ST_NOCAND};
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              div_dvd   <= DVW'(cur.random_value);
              div_dvs   <= QW'(cnt);
              div_start <= 1'b1;
              state     <= S_DIVW;
            end
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if (cur.operation == qle_pkg::OP_UPDATE) begin
              state <= S_UFIN;
            end else begin
              pick  <= div_rem[CW-1:0];
              k     <= '0;
              found <= 1'b0;
              col <= '0; srow <= cur.from_node[NW-1:0]; whole <= 1'b0;
              issuing <= 1'b1; fresh <= 1'b1;
              state <= S_FIND;
            end
          end
        end
        // Walk to the picked candidate
        S_FIND: begin
          if (pvld && hit && !found) begin
            if (k == pick) begin
              chosen <= 8'(pcol);
              found  <= 1'b1;
            end
            k <= k + 1'b1;
          end
          if (scan_done) begin
            result <= '{chosen_node: chosen, score: 32'sd0, status: qle_pkg::ST_OK};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_URD: state <= S_URC;
        S_URC: begin
          rcode <= rd_code;
          col <= '0; srow <= cur.to_node[NW-1:0]; whole <= 1'b0;
          issuing <= 1'b1; fresh <= 1'b1;
          state <= S_RMAX;
        end
        S_UMUL: begin
          prod  <= $signed({1'b0, gamma}) * m;
          state <= S_URND;
        end
        S_URND: begin
          rndv  <= prnd[40:16];
          state <= S_UWR;
        end
        S_UWR: begin
          col <= '0; srow <= '0; whole <= 1'b1; issuing <= 1'b1; fresh <= 1'b1;
          state <= S_SUM;
        end
        // Table sum and maximum
        S_SUM: begin
          if (pvld) begin
            sum  <= pfirst ? q_ext : (sum + q_ext);
            tmax <= (pfirst || (rd_q > tmax)) ? rd_q : tmax;
          end
          if (scan_done) begin
            state <= S_SCL;
          end
        end
        S_SCL: begin
          if (tmax <= 0) begin
            result <= '{chosen_node: 8'd0, score: 32'sd0, status: qle_pkg::ST_NONPOS};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            p100  <= (sum_x <<< 6) + (sum_x <<< 5) + (sum_x <<< 2);
            state <= S_SABS;
          end
        end
        S_SABS: begin
          neg       <= p100[DVW-1];
          div_dvd   <= p100[DVW-1] ? (DVW'(0) - p100) : p100;
          div_dvs   <= tmax;
          div_start <= 1'b1;
          state     <= S_DIVW;
        end
        S_UFIN: begin
          result <= '{chosen_node: 8'd0, score: score_sat, status: qle_pkg::ST_OK};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  qle_store #(
    .NW(NW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_row   (rd_row),
    .rd_col   (rd_col),
    .wr_row   (wr_row),
    .wr_col   (wr_col),
    .wr       (wr),
    .goal_set (goal_set),
    .goal_node(cfg_data[NW-1:0]),
    .rd_code  (rd_code),
    .rd_q     (rd_q),
    .clearing (clearing)
  );

  qle_div #(
    .DW(DVW),
    .VW(QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  `QLE_ASSERT(done_when_idle, clk, rst, done |-> !busy)
  `QLE_ASSERT(accept_progress, clk, rst, (start && !busy) |=> (busy || done))
  `QLE_NEVER(div_start_busy, clk, rst, div_start && (state != S_DIVW))

endmodule
